@@ design/positional_deque_assert.svh @@
`ifndef POSITIONAL_DEQUE_ASSERT_SVH
`define POSITIONAL_DEQUE_ASSERT_SVH

// Check on the cycle after the antecedent.
`define PD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check in the same cycle as the antecedent.
`define PD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/pd_pkg.sv @@
`default_nettype none
package pd_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_INSERT     = 3'd4;
  localparam logic [2:0] CMD_DELETE     = 3'd5;
  localparam logic [2:0] CMD_REVERSE    = 3'd6;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_BAD_POS = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    K_UPDATE    = 2'd0,
    K_ADD_FIRST = 2'd1,
    K_INSERT    = 2'd2,
    K_DELETE    = 2'd3
  } pd_kind_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic finish;
    logic rd_first;
    logic rd_last;
    logic rd_back;
    logic out_load;
  } pd_cmd_t;

  typedef struct packed {
    pd_kind_t kind;
    logic     shift_more;
    logic     empty;
  } pd_stat_t;

endpackage
`default_nettype wire

@@ design/pd_ctrl.sv @@
`default_nettype none
`include "positional_deque_assert.svh"
module pd_ctrl import pd_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  wire      out_tready,
  output pd_cmd_t  cmd_o,
  input  pd_stat_t stat_i
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_EXEC     = 10'b0000000010,
    S_LOOP     = 10'b0000000100,
    S_SH_RD    = 10'b0000001000,
    S_SH_WR    = 10'b0000010000,
    S_FIN      = 10'b0000100000,
    S_RD_FIRST = 10'b0001000000,
    S_RD_LAST  = 10'b0010000000,
    S_RD_BACK  = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.kind == K_INSERT || stat_i.kind == K_DELETE) state_nxt = S_LOOP;
        else state_nxt = S_RD_FIRST;
      end
      S_LOOP:  state_nxt = stat_i.shift_more ? S_SH_RD : S_FIN;
      S_SH_RD: begin
        cmd_o.shift_rd = 1'b1;
        state_nxt      = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_nxt      = S_LOOP;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_nxt    = S_RD_FIRST;
      end
      S_RD_FIRST: begin
        if (stat_i.empty) begin
          state_nxt = S_OUT;
        end else begin
          cmd_o.rd_first = 1'b1;
          state_nxt      = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        cmd_o.rd_last = 1'b1;
        state_nxt     = S_RD_BACK;
      end
      S_RD_BACK: begin
        cmd_o.rd_back = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd_o.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `PD_ASSERT_NEXT(a_accept_exec, in_tvalid && in_tready, state_r == S_EXEC, "accept not followed by execute")
  `PD_ASSERT_NEXT(a_read_write, state_r == S_SH_RD, state_r == S_SH_WR, "shift read without write")
  `PD_ASSERT_NEXT(a_load_valid, cmd_o.out_load, out_tvalid, "result load lost")

endmodule
`default_nettype wire

@@ design/pd_datapath.sv @@
`default_nettype none
module pd_datapath import pd_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire  [47:0]      in_tdata,
  output logic [79:0]      out_tdata,
  input  pd_cmd_t          cmd_i,
  output pd_stat_t         stat_o
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > 9) ? CW : 9) + 1;
  localparam logic [CW:0] CAP_X = (CW + 1)'(CAPACITY);

  logic [2:0]        cmd_r;
  logic [31:0]       val_r;
  logic [8:0]        pos_r;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              rev_r, rev_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     s_r, s_nxt;
  logic              del_r, del_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [31:0]       rdata_r;
  logic [31:0]       front_val_r, back_val_r;
  logic [79:0]       out_r;
  logic [31:0]       store_r [CAPACITY];

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] f, input logic [CW-1:0] x);
    logic [CW:0] sum;
    sum = (CW + 1)'(f) + (CW + 1)'(x);
    if (sum >= CAP_X) sum = sum - CAP_X;
    return sum[AW-1:0];
  endfunction

  logic [CMPW-1:0] posx, cntx;
  logic            full, is_empty;
  pd_kind_t        kind;
  logic [1:0]      code;
  logic            drop_first, dec_cnt, toggle;
  logic [CW-1:0]   s_calc;
  logic [CMPW-1:0] s_wide;

  assign posx     = CMPW'(pos_r);
  assign cntx     = CMPW'(cnt_r);
  assign full     = cntx >= CMPW'(CAPACITY);
  assign is_empty = (cnt_r == '0);
  assign s_calc   = s_wide[CW-1:0];

  always_comb begin
    kind       = K_UPDATE;
    code       = ST_DONE;
    drop_first = 1'b0;
    dec_cnt    = 1'b0;
    toggle     = 1'b0;
    s_wide     = '0;
    unique case (cmd_r)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) code = ST_FULL;
        else if ((cmd_r == CMD_PUSH_FRONT) != rev_r) kind = K_ADD_FIRST;
        else begin
          kind   = K_INSERT;
          s_wide = cntx;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (is_empty) code = ST_EMPTY;
        else if ((cmd_r == CMD_POP_FRONT) != rev_r) drop_first = 1'b1;
        else dec_cnt = 1'b1;
      end
      CMD_INSERT: begin
        if (pos_r == '0 || posx > cntx + CMPW'(1)) code = ST_BAD_POS;
        else if (full) code = ST_FULL;
        else begin
          kind   = K_INSERT;
          s_wide = rev_r ? cntx - (posx - CMPW'(1)) : posx - CMPW'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_r == '0 || posx > cntx) code = ST_BAD_POS;
        else begin
          kind   = K_DELETE;
          s_wide = rev_r ? cntx - posx : posx - CMPW'(1);
        end
      end
      CMD_REVERSE: toggle = 1'b1;
      default: ;
    endcase
  end

  logic [CMPW-1:0] j_x;
  assign j_x = CMPW'(j_r);

  assign stat_o.kind       = kind;
  assign stat_o.empty      = is_empty;
  assign stat_o.shift_more = del_r ? (j_x + CMPW'(1) < cntx) : (j_r > s_r);

  logic [AW-1:0] front_dec, front_inc;
  assign front_dec = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(CAPACITY - 1)) ? '0 : front_r + AW'(1);

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data;
  logic [CW-1:0] last_s, first_s;

  assign last_s  = cnt_r - CW'(1);
  assign first_s = rev_r ? last_s : '0;

  always_comb begin
    front_nxt  = front_r;
    cnt_nxt    = cnt_r;
    rev_nxt    = rev_r;
    j_nxt      = j_r;
    s_nxt      = s_r;
    del_nxt    = del_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = val_r;
    rd_en      = 1'b0;
    rd_addr    = phys(front_r, rev_r ? '0 : last_s);
    if (cmd_i.exec) begin
      status_nxt = code;
      del_nxt    = (kind == K_DELETE);
      s_nxt      = s_calc;
      j_nxt      = (kind == K_DELETE) ? s_calc : cnt_r;
      if (toggle) rev_nxt = ~rev_r;
      if (drop_first) front_nxt = front_inc;
      if (drop_first || dec_cnt) cnt_nxt = cnt_r - CW'(1);
      if (kind == K_ADD_FIRST) begin
        front_nxt = front_dec;
        cnt_nxt   = cnt_r + CW'(1);
        wr_en     = 1'b1;
        wr_addr   = front_dec;
      end
    end
    if (cmd_i.shift_rd) begin
      rd_en   = 1'b1;
      rd_addr = phys(front_r, del_r ? j_r + CW'(1) : j_r - CW'(1));
    end
    if (cmd_i.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = phys(front_r, j_r);
      wr_data = rdata_r;
      j_nxt   = del_r ? j_r + CW'(1) : j_r - CW'(1);
    end
    if (cmd_i.finish) begin
      if (del_r) begin
        cnt_nxt = cnt_r - CW'(1);
      end else begin
        wr_en   = 1'b1;
        wr_addr = phys(front_r, s_r);
        cnt_nxt = cnt_r + CW'(1);
      end
    end
    if (cmd_i.rd_first) begin
      rd_en   = 1'b1;
      rd_addr = phys(front_r, first_s);
    end
    if (cmd_i.rd_last) rd_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_r[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= store_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
      rev_r   <= 1'b0;
    end else begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
      rev_r   <= rev_nxt;
    end
  end

  logic [CMPW-1:0] cnt_out;
  assign cnt_out = CMPW'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r <= in_tdata[2:0];
      val_r <= in_tdata[34:3];
      pos_r <= in_tdata[43:35];
    end
    j_r      <= j_nxt;
    s_r      <= s_nxt;
    del_r    <= del_nxt;
    status_r <= status_nxt;
    if (cmd_i.rd_last) front_val_r <= rdata_r;
    if (cmd_i.rd_back) back_val_r <= rdata_r;
    if (cmd_i.out_load) begin
      out_r <= {4'd0, is_empty, cnt_out[8:0],
                is_empty ? 32'd0 : back_val_r,
                is_empty ? 32'd0 : front_val_r, status_r};
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

@@ design/positional_deque.sv @@
// Bounded double-ended queue of signed 32-bit values in a ring memory of CAPACITY
// entries. Each input beat is one command (push front/back, pop front/back, insert or
// delete at a 1-based position, reverse) and yields exactly one result beat with the
// status, first and last values, count and empty flag. The block takes one command at
// a time. Insert and delete move each stored entry between the position and one end of
// the queue one place, one read and one write at a time, through the single read and
// single write port of the ring memory. The result is loaded only once the previous
// result beat has been taken, and a new command is accepted on the cycle after the
// result is loaded.
`default_nettype none
module positional_deque import pd_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // cmd[2:0], value[34:3], position[43:35]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [79:0] out_tdata   // status[1:0], front_value[33:2], back_value[65:34],
                                  // count[74:66], is_empty[75]
);

  pd_cmd_t  cmd;
  pd_stat_t stat;

  pd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  pd_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

endmodule
`default_nettype wire
